FILE: rtl/csv_record_tokenizer_assert.svh
// Assertion macros used by the checker file of the CSV record tokenizer.
// Needs a clock named i_clk and an active-low reset named i_rst_n in scope.
`ifndef CSV_RECORD_TOKENIZER_ASSERT_SVH
`define CSV_RECORD_TOKENIZER_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define CSVT_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define CSVT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/csvt_pkg.sv
// Package of the CSV record tokenizer: payload types, codes and reset values.
// No dependencies; every module of the block imports it.
package csvt_pkg;

    // Input operations
    localparam logic OP_UNIT = 1'b0;
    localparam logic OP_EOT  = 1'b1;

    // Result kinds
    localparam logic [1:0] KIND_DATA   = 2'd0;
    localparam logic [1:0] KIND_FIELD  = 2'd1;
    localparam logic [1:0] KIND_RECORD = 2'd2;
    localparam logic [1:0] KIND_ERR    = 2'd3;

    // Error codes
    localparam logic [2:0] ERR_COLS        = 3'd0;
    localparam logic [2:0] ERR_CELLS       = 3'd1;
    localparam logic [2:0] ERR_AFTER_CLOSE = 3'd2;
    localparam logic [2:0] ERR_STRAY_QUOTE = 3'd3;
    localparam logic [2:0] ERR_UNTERM      = 3'd4;

    // Configuration register indexes
    localparam logic [1:0] CFG_DELIM     = 2'd0;
    localparam logic [1:0] CFG_MAX_COLS  = 2'd1;
    localparam logic [1:0] CFG_MAX_CELLS = 2'd2;

    localparam int CFG_DATA_W = 21;

    // Special code units
    localparam logic [15:0] CU_QUOTE = 16'd34;
    localparam logic [15:0] CU_CR    = 16'd13;
    localparam logic [15:0] CU_LF    = 16'd10;

    // Register reset values
    localparam logic [15:0] DELIM_RESET     = 16'd44;
    localparam logic [14:0] MAX_COLS_RESET  = 15'd16384;
    localparam logic [20:0] MAX_CELLS_RESET = 21'd2000000;

    // Default depth of the queue between front and back (2 or more)
    localparam int CSVT_QUEUE_DEPTH = 4;

    typedef struct packed {
        logic        op;
        logic [15:0] code_unit;
    } t_item;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] data_unit;
        logic [2:0]  error_code;
        logic [20:0] error_row;
        logic [14:0] error_field;
        logic [25:0] error_line;
        logic [25:0] error_char;
    } t_result;

    // Classified item as it sits in the queue
    typedef struct packed {
        logic        op;
        logic [15:0] code_unit;
        logic        is_quote;
        logic        is_cr;
        logic        is_lf;
        logic        is_delim;
    } t_cls;

    typedef struct packed {
        logic [14:0] max_columns;
        logic [20:0] max_cells;
    } t_limits;

    typedef enum logic [2:0] {
        S_START  = 3'd0,
        S_UNQ    = 3'd1,
        S_QUOTED = 3'd2,
        S_PEND   = 3'd3,
        S_CLOSED = 3'd4,
        S_HALT   = 3'd5
    } t_pstate;

    // What one item does in the back end
    typedef enum logic [3:0] {
        STP_NONE,
        STP_EOT,
        STP_QQUOTE,
        STP_QNL,
        STP_QDATA,
        STP_PQUOTE,
        STP_SKIP,
        STP_DELIM,
        STP_NEWLINE,
        STP_AFTER_CLOSE,
        STP_OPEN,
        STP_STRAY,
        STP_DATA
    } t_step;

endpackage

FILE: rtl/csvt_queue.sv
// Short register queue that parts the front and back of the tokenizer.
// Depends on csvt_pkg for the entry type.
module csvt_queue import csvt_pkg::*; #(
    parameter int DEPTH = CSVT_QUEUE_DEPTH
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cls i_entry,
    output logic o_full,
    output logic o_valid,
    output t_cls o_entry,
    input  logic i_pop
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_cls          r_mem [DEPTH];
    logic [PW-1:0] r_wr;
    logic [PW-1:0] r_rd;
    logic [CW-1:0] r_count;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_entry = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + PW'(1);
            end
            if (i_pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + PW'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CW'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - CW'(1);
            end
        end
    end
endmodule

FILE: rtl/csvt_front.sv
// Front end of the tokenizer: input handshake and code unit classification.
// Depends on csvt_pkg; feeds csvt_queue.
module csvt_front import csvt_pkg::*; (
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_item       i_in,
    input  logic [15:0] i_delim,
    input  logic        i_q_full,
    output logic        o_push,
    output t_cls        o_entry
);
    assign o_in_stall = i_q_full;
    assign o_push     = i_in_valid && !i_q_full;

    always_comb begin
        o_entry.op        = i_in.op;
        o_entry.code_unit = i_in.code_unit;
        o_entry.is_quote  = (i_in.code_unit == CU_QUOTE);
        o_entry.is_cr     = (i_in.code_unit == CU_CR);
        o_entry.is_lf     = (i_in.code_unit == CU_LF);
        o_entry.is_delim  = (i_in.code_unit == i_delim);
    end
endmodule

FILE: rtl/csvt_back.sv
// Back end of the tokenizer: quoting state machine, counters and result register.
// Depends on csvt_pkg; pulls classified items from csvt_queue.
module csvt_back import csvt_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_q_valid,
    input  t_cls    i_q_data,
    output logic    o_q_pop,
    input  t_limits i_limits,
    output logic    o_out_valid,
    output t_result o_out,
    input  logic    i_out_stall
);
    function automatic logic [14:0] sat15(input logic [14:0] v);
        return (&v) ? v : v + 15'd1;
    endfunction

    function automatic logic [20:0] sat21(input logic [20:0] v);
        return (&v) ? v : v + 21'd1;
    endfunction

    function automatic logic [24:0] sat25(input logic [24:0] v);
        return (&v) ? v : v + 25'd1;
    endfunction

    t_pstate     r_state, n_state;
    logic        r_prev_cr, n_prev_cr;
    logic        r_started, n_started;
    logic [14:0] r_fields, n_fields;
    logic [20:0] r_cells, n_cells;
    logic [20:0] r_records, n_records;
    logic [24:0] r_line, n_line;
    logic [24:0] r_char, n_char;
    logic        r_out_valid;
    t_result     r_out;

    t_step       step;
    t_pstate     eff_state;
    logic        advance_ok;
    logic        crlf;
    logic        is_nl;
    logic        col_fail;
    logic        cell_fail;
    logic        fe_fail;
    logic        res_valid;
    logic        res_err;
    logic [1:0]  res_kind;
    logic [2:0]  res_code;
    t_result     res;

    assign advance_ok  = !r_out_valid || !i_out_stall;
    assign o_q_pop     = i_q_valid && advance_ok;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    assign crlf      = r_prev_cr && i_q_data.is_lf;
    assign is_nl     = i_q_data.is_cr || i_q_data.is_lf;
    assign eff_state = (r_state == S_PEND) ? S_CLOSED : r_state;
    assign col_fail  = (r_fields >= i_limits.max_columns);
    assign cell_fail = (r_cells >= i_limits.max_cells);
    assign fe_fail   = col_fail || cell_fail;

    // Decode what the item at the queue head does
    always_comb begin
        if (i_q_data.op == OP_EOT) begin
            step = STP_EOT;
        end else if (r_state == S_HALT) begin
            step = STP_NONE;
        end else if (r_state == S_QUOTED) begin
            if (i_q_data.is_quote) begin
                step = STP_QQUOTE;
            end else if (is_nl) begin
                step = STP_QNL;
            end else begin
                step = STP_QDATA;
            end
        end else if (r_state == S_PEND && i_q_data.is_quote) begin
            step = STP_PQUOTE;
        end else if (crlf) begin
            step = STP_SKIP;
        end else if (i_q_data.is_delim) begin
            step = STP_DELIM;
        end else if (is_nl) begin
            step = STP_NEWLINE;
        end else if (eff_state == S_CLOSED) begin
            step = STP_AFTER_CLOSE;
        end else if (i_q_data.is_quote) begin
            step = (eff_state != S_START) ? STP_STRAY : STP_OPEN;
        end else begin
            step = STP_DATA;
        end
    end

    // Next parse state
    always_comb begin
        n_state = r_state;
        unique case (step)
            STP_EOT:                   n_state = S_START;
            STP_QQUOTE:                n_state = S_PEND;
            STP_PQUOTE, STP_OPEN:      n_state = S_QUOTED;
            STP_SKIP:                  n_state = eff_state;
            STP_DELIM, STP_NEWLINE:    n_state = fe_fail ? S_HALT : S_START;
            STP_AFTER_CLOSE, STP_STRAY: n_state = S_HALT;
            STP_DATA:                  n_state = S_UNQ;
            default:                   n_state = r_state;
        endcase
    end

    // Counters and flags
    always_comb begin
        n_prev_cr = (step == STP_NONE) ? r_prev_cr : 1'b0;
        n_started = r_started;
        n_fields  = r_fields;
        n_cells   = r_cells;
        n_records = r_records;
        n_line    = r_line;
        n_char    = r_char;
        case (step)
            STP_EOT: begin
                n_started = 1'b0;
                n_fields  = '0;
                n_cells   = '0;
                n_records = '0;
                n_line    = 25'd1;
                n_char    = 25'd1;
            end
            STP_QQUOTE, STP_QDATA, STP_PQUOTE: begin
                n_char = sat25(r_char);
            end
            STP_QNL: begin
                if (!crlf) begin
                    n_line    = sat25(r_line);
                    n_char    = 25'd1;
                    n_prev_cr = i_q_data.is_cr;
                end
            end
            STP_DELIM: begin
                if (!fe_fail) begin
                    n_cells   = r_cells + 21'd1;
                    n_fields  = sat15(r_fields);
                    n_started = 1'b1;
                    n_char    = sat25(r_char);
                end
            end
            STP_NEWLINE: begin
                if (!fe_fail) begin
                    n_cells   = r_cells + 21'd1;
                    n_fields  = '0;
                    n_records = sat21(r_records);
                    n_started = 1'b0;
                    n_line    = sat25(r_line);
                    n_char    = 25'd1;
                    n_prev_cr = i_q_data.is_cr;
                end
            end
            STP_OPEN, STP_DATA: begin
                n_started = 1'b1;
                n_char    = sat25(r_char);
            end
            default: begin
            end
        endcase
    end

    // Result of the item
    always_comb begin
        res_valid = 1'b0;
        res_err   = 1'b0;
        res_kind  = KIND_DATA;
        res_code  = ERR_COLS;
        case (step)
            STP_EOT: begin
                if (r_state == S_QUOTED) begin
                    res_valid = 1'b1;
                    res_err   = 1'b1;
                    res_code  = ERR_UNTERM;
                end else if (r_state != S_HALT && r_started) begin
                    res_valid = 1'b1;
                    res_err   = fe_fail;
                    res_code  = col_fail ? ERR_COLS : ERR_CELLS;
                    res_kind  = KIND_RECORD;
                end
            end
            STP_QNL, STP_QDATA, STP_PQUOTE, STP_DATA: begin
                res_valid = 1'b1;
                res_kind  = KIND_DATA;
            end
            STP_DELIM: begin
                res_valid = 1'b1;
                res_err   = fe_fail;
                res_code  = col_fail ? ERR_COLS : ERR_CELLS;
                res_kind  = KIND_FIELD;
            end
            STP_NEWLINE: begin
                res_valid = 1'b1;
                res_err   = fe_fail;
                res_code  = col_fail ? ERR_COLS : ERR_CELLS;
                res_kind  = KIND_RECORD;
            end
            STP_AFTER_CLOSE: begin
                res_valid = 1'b1;
                res_err   = 1'b1;
                res_code  = ERR_AFTER_CLOSE;
            end
            STP_STRAY: begin
                res_valid = 1'b1;
                res_err   = 1'b1;
                res_code  = ERR_STRAY_QUOTE;
            end
            default: begin
            end
        endcase

        res = '0;
        if (res_err) begin
            res.kind        = KIND_ERR;
            res.error_code  = res_code;
            res.error_row   = sat21(r_records);
            res.error_field = sat15(r_fields);
            res.error_line  = {1'b0, r_line};
            res.error_char  = {1'b0, r_char};
        end else begin
            res.kind = res_kind;
            if (res_kind == KIND_DATA) begin
                res.data_unit = i_q_data.code_unit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_START;
            r_prev_cr   <= 1'b0;
            r_started   <= 1'b0;
            r_fields    <= '0;
            r_cells     <= '0;
            r_records   <= '0;
            r_line      <= 25'd1;
            r_char      <= 25'd1;
            r_out_valid <= 1'b0;
        end else begin
            if (o_q_pop) begin
                r_state   <= n_state;
                r_prev_cr <= n_prev_cr;
                r_started <= n_started;
                r_fields  <= n_fields;
                r_cells   <= n_cells;
                r_records <= n_records;
                r_line    <= n_line;
                r_char    <= n_char;
            end
            if (advance_ok) begin
                r_out_valid <= o_q_pop && res_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance_ok) begin
            r_out <= res;
        end
    end
endmodule

FILE: rtl/csv_record_tokenizer.sv
// Top level of the CSV record tokenizer: configuration registers and the
// front, queue and back instances. Depends on csvt_pkg, csvt_front,
// csvt_queue and csvt_back.
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_in): one beat is one UTF-16
//   code unit of text (op = unit) or the end-of-text marker (op = eot).
//   Output channel (o_out_valid / i_out_stall / o_out): at most one beat per
//   input beat: a field data unit, a field end, a record end or one error
//   with its row, field, line and character position.
//   Configuration: write delimiter, column limit or cell limit through
//   i_cfg_we / i_cfg_idx / i_cfg_data while the block is idle.
//   Path: an input beat is held in the queue, and its result in the result
//   register on o_out. Throughput: one code unit per cycle unless the
//   receiver stalls; the back end updates parse state and counters at once.
//   Receiver stall: the result register holds its beat, the queue absorbs
//   up to QUEUE_DEPTH more beats, then o_in_stall rises.
//   Reset: queue empties, parse state and counters clear, registers return
//   to delimiter ',', 16384 columns and 2000000 cells.
//   After an error the block drops code units until end of text, which
//   gives no beat and clears the parse state.
module csv_record_tokenizer import csvt_pkg::*; #(
    parameter int QUEUE_DEPTH = CSVT_QUEUE_DEPTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_item                 i_in,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_result               o_out,
    input  logic                  i_cfg_we,
    input  logic [1:0]            i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);
    logic [15:0] r_delim;
    t_limits     r_limits;

    logic q_full;
    logic q_push;
    t_cls q_in;
    logic q_valid;
    t_cls q_out;
    logic q_pop;

    // Configuration registers; writes beyond the last index are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delim              <= DELIM_RESET;
            r_limits.max_columns <= MAX_COLS_RESET;
            r_limits.max_cells   <= MAX_CELLS_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_DELIM:     r_delim              <= i_cfg_data[15:0];
                CFG_MAX_COLS:  r_limits.max_columns <= i_cfg_data[14:0];
                CFG_MAX_CELLS: r_limits.max_cells   <= i_cfg_data[20:0];
                default: begin
                end
            endcase
        end
    end

    // Front: take the beat and classify the code unit
    csvt_front u_front (
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in       (i_in),
        .i_delim    (r_delim),
        .i_q_full   (q_full),
        .o_push     (q_push),
        .o_entry    (q_in)
    );

    // Queue: lets the front keep taking beats while the back waits
    csvt_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_entry (q_in),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_entry (q_out),
        .i_pop   (q_pop)
    );

    // Back: advance the quoting state and register the result
    csvt_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_data    (q_out),
        .o_q_pop     (q_pop),
        .i_limits    (r_limits),
        .o_out_valid (o_out_valid),
        .o_out       (o_out),
        .i_out_stall (i_out_stall)
    );
endmodule

FILE: rtl/csvt_checker.sv
// Port-level checks of the CSV record tokenizer, bound to the top level.
// Depends on csvt_pkg and csv_record_tokenizer_assert.svh.
`include "csv_record_tokenizer_assert.svh"

module csvt_checker import csvt_pkg::*; (
    input logic    i_clk,
    input logic    i_rst_n,
    input logic    o_in_stall,
    input logic    o_out_valid,
    input logic    i_out_stall,
    input t_result o_out
);
    // Hold a stalled result beat
    `CSVT_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid && $stable(o_out), "stalled result beat changed")

    // Input backs up only when the result side was stalled with a beat
    `CSVT_ASSERT_NOW(a_stall_cause, o_in_stall, $past(o_out_valid && i_out_stall), "input stalled without output backpressure")

    // Error beats carry one of the defined error codes
    `CSVT_ASSERT_NOW(a_err_code, o_out_valid && o_out.kind == KIND_ERR, o_out.error_code <= ERR_UNTERM, "bad error code")
endmodule

bind csv_record_tokenizer csvt_checker u_chk (.*);
